[src/pafr_pkg.sv]
// Package for the polar-axis frame rotation block: widths, constants, stage types
// and the arithmetic step functions shared by the pipeline.
// No dependencies.
`default_nettype none

package pafr_pkg;

  localparam int COORD_W    = 32;
  localparam int AXIS_FRAC  = 30;
  localparam int AXIS_W     = AXIS_FRAC + 2;
  localparam int THR_W      = 31;
  localparam int ROOT_W     = AXIS_FRAC + 1;
  localparam int RAD_W      = 2 * AXIS_FRAC + 2;
  localparam int SQ_STAGES  = AXIS_FRAC + 1;
  localparam int PROD_W     = 64;
  localparam int DIVD_W     = 63;
  localparam int REM_W      = ROOT_W;
  localparam int DIV_STAGES = DIVD_W;
  localparam int RND_W      = PROD_W - AXIS_FRAC + 2;
  localparam int SUM_W      = PROD_W + 2;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic signed [AXIS_W-1:0] AXIS_ONE = AXIS_W'(1) << AXIS_FRAC;
  localparam logic signed [PROD_W-1:0] ONE_SQ   = PROD_W'(1) << (2 * AXIS_FRAC);
  localparam logic signed [PROD_W-1:0] RND_POS  = PROD_W'(1) << (AXIS_FRAC - 1);
  localparam logic signed [PROD_W-1:0] RND_NEG  = RND_POS - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] BIG_QUOT = PROD_W'(1) << 62;
  localparam logic [RAD_W-1:0]         ROOT_MAX = RAD_W'(1) << AXIS_FRAC;
  localparam logic [THR_W-1:0]         THR_RESET = THR_W'(1);
  localparam logic signed [SUM_W-1:0]  SAT_HI = (SUM_W'(1) << (COORD_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0]  SAT_LO = -SAT_HI - SUM_W'(1);

  localparam logic REG_THRESHOLD = 1'b0;

  typedef enum logic [1:0] {
    MODE_L2G      = 2'b00,
    MODE_L2G_SPEC = 2'b01,
    MODE_G2L      = 2'b10,
    MODE_G2L_SPEC = 2'b11
  } mode_t;

  typedef struct packed {
    logic                      op;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [AXIS_W-1:0]  u;
    logic signed [AXIS_W-1:0]  v;
    logic signed [AXIS_W-1:0]  w;
    logic signed [AXIS_W-1:0]  uw;
    logic signed [AXIS_W-1:0]  vw;
    logic signed [AXIS_W-1:0]  uv;
  } geo_t;

  typedef struct packed {
    logic signed [RND_W-1:0] da;
    logic signed [RND_W-1:0] db;
    logic signed [RND_W-1:0] dc;
    logic                    n1_neg;
    logic                    n2_neg;
    logic                    n1_nz;
    logic                    n2_nz;
    logic                    dz;
    logic                    q2_to_c;
    logic                    special;
  } tail_t;

  function automatic logic signed [AXIS_W-1:0] clamp_axis(input logic signed [AXIS_W-1:0] a);
    if (a > AXIS_ONE) return AXIS_ONE;
    if (a < -AXIS_ONE) return -AXIS_ONE;
    return a;
  endfunction

  function automatic logic signed [RND_W-1:0] round_q46(input logic signed [PROD_W-1:0] a);
    logic signed [PROD_W-1:0] t;
    t = a + (a[PROD_W-1] ? RND_NEG : RND_POS);
    return RND_W'(t >>> AXIS_FRAC);
  endfunction

  function automatic logic [2*RAD_W-1:0] sqrt_step(input logic [RAD_W-1:0] x,
                                                   input logic [RAD_W-1:0] r,
                                                   input logic [RAD_W-1:0] bt);
    logic [RAD_W-1:0] trial;
    trial = r + bt;
    if (x >= trial) return {x - trial, (r >> 1) + bt};
    return {x, r >> 1};
  endfunction

  function automatic logic [DIVD_W+REM_W-1:0] div_step(input logic [DIVD_W-1:0] num,
                                                       input logic [REM_W-1:0]  rem,
                                                       input logic [ROOT_W-1:0] d);
    logic [REM_W:0] t;
    logic           ge;
    t  = {rem, num[DIVD_W-1]};
    ge = (t >= {1'b0, d});
    return {num[DIVD_W-2:0], ge, REM_W'(ge ? t - {1'b0, d} : t)};
  endfunction

  function automatic logic [COORD_W:0] sat_coord(input logic signed [SUM_W-1:0] a);
    if (a > SAT_HI) return {1'b1, COORD_W'(SAT_HI)};
    if (a < SAT_LO) return {1'b1, COORD_W'(SAT_LO)};
    return {1'b0, COORD_W'(a)};
  endfunction

endpackage

`default_nettype wire

[src/polar_axis_frame_rotation_top.sv]
// Top level of the polar-axis frame rotation block: fully pipelined rotation with
// square-root and divider pipelines and an APB-style threshold register.
// Depends on pafr_pkg.
`default_nettype none

// The block rotates one Q16.16 vector per cycle while the output is not stalled,
// between a local frame and the global frame. The pipeline is made of the 31-stage
// square-root pipeline, one root bit per stage, and the 63-stage divider pipeline,
// one quotient bit per stage, plus nine stages for clamping, products, sums,
// rounding and saturation. A stalled output holds the whole pipeline in place.
// The user must write the threshold register only while no transfer is in flight;
// the block itself does not enforce it.
module polar_axis_frame_rotation_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_op,
  input  logic signed [pafr_pkg::COORD_W-1:0]  in_coord_a,
  input  logic signed [pafr_pkg::COORD_W-1:0]  in_coord_b,
  input  logic signed [pafr_pkg::COORD_W-1:0]  in_coord_c,
  input  logic signed [pafr_pkg::AXIS_W-1:0]   in_axis_u,
  input  logic signed [pafr_pkg::AXIS_W-1:0]   in_axis_v,
  input  logic signed [pafr_pkg::AXIS_W-1:0]   in_axis_w,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pafr_pkg::COORD_W-1:0] out_a,
  output logic signed [pafr_pkg::COORD_W-1:0] out_b,
  output logic signed [pafr_pkg::COORD_W-1:0] out_c,
  output logic                                 out_used_special_case,
  output logic                                 out_saturated,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pafr_pkg::ADDR_W-1:0]          paddr,
  input  logic [pafr_pkg::DATA_W-1:0]          pwdata,
  output logic [pafr_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready
);
  import pafr_pkg::*;

  localparam int SQL = SQ_STAGES - 1;
  localparam int DVL = DIV_STAGES - 1;

  logic              adv;
  logic [THR_W-1:0]  thr_r;

  logic              v1_r;
  geo_t              g1_r;

  logic              v2_r;
  geo_t              g2_r;
  logic signed [PROD_W-1:0] ww2_r, vv2_r, uwp2_r, vwp2_r, uvp2_r;

  logic              v3_r;
  geo_t              g3_r;
  logic [RAD_W-1:0]  radw3_r, radv3_r;

  logic [RAD_W-1:0]  swx_in [SQ_STAGES];
  logic [RAD_W-1:0]  swr_in [SQ_STAGES];
  logic [RAD_W-1:0]  svx_in [SQ_STAGES];
  logic [RAD_W-1:0]  svr_in [SQ_STAGES];
  logic [RAD_W-1:0]  swx_nxt [SQ_STAGES];
  logic [RAD_W-1:0]  swr_nxt [SQ_STAGES];
  logic [RAD_W-1:0]  svx_nxt [SQ_STAGES];
  logic [RAD_W-1:0]  svr_nxt [SQ_STAGES];
  logic [RAD_W-1:0]  swx_r [SQ_STAGES];
  logic [RAD_W-1:0]  swr_r [SQ_STAGES];
  logic [RAD_W-1:0]  svx_r [SQ_STAGES];
  logic [RAD_W-1:0]  svr_r [SQ_STAGES];
  geo_t              sg_r [SQ_STAGES];
  logic              sv_r [SQ_STAGES];

  logic              v4_r;
  geo_t              g4_r;
  logic [ROOT_W-1:0] s4_r;
  logic              spec4_r;

  logic              v5_r;
  logic [ROOT_W-1:0] s5_r;
  mode_t             mode5_r;
  mode_t             mode5_nxt;
  logic signed [AXIS_W-1:0]  ma [8];
  logic signed [COORD_W-1:0] mb [8];
  logic signed [PROD_W-1:0]  p5_r [8];

  logic              v6_r;
  logic [ROOT_W-1:0] s6_r;
  mode_t             mode6_r;
  logic signed [PROD_W-1:0] n1_nxt, n2_nxt, da_nxt, db_nxt, dc_nxt;
  logic signed [PROD_W-1:0] n1_r, n2_r, da6_r, db6_r, dc6_r;

  logic              v7_r;
  logic [ROOT_W-1:0] d7_r;
  logic [DIVD_W-1:0] m1_r, m2_r;
  tail_t             t7_r;
  logic signed [PROD_W-1:0] half6;

  logic [DIVD_W-1:0] dn1_in [DIV_STAGES];
  logic [REM_W-1:0]  dr1_in [DIV_STAGES];
  logic [DIVD_W-1:0] dn2_in [DIV_STAGES];
  logic [REM_W-1:0]  dr2_in [DIV_STAGES];
  logic [ROOT_W-1:0] dd_in  [DIV_STAGES];
  logic [DIVD_W-1:0] dn1_nxt [DIV_STAGES];
  logic [REM_W-1:0]  dr1_nxt [DIV_STAGES];
  logic [DIVD_W-1:0] dn2_nxt [DIV_STAGES];
  logic [REM_W-1:0]  dr2_nxt [DIV_STAGES];
  logic [DIVD_W-1:0] dn1_r [DIV_STAGES];
  logic [REM_W-1:0]  dr1_r [DIV_STAGES];
  logic [DIVD_W-1:0] dn2_r [DIV_STAGES];
  logic [REM_W-1:0]  dr2_r [DIV_STAGES];
  logic [ROOT_W-1:0] dd_r  [DIV_STAGES];
  tail_t             dt_r  [DIV_STAGES];
  logic              dv_r  [DIV_STAGES];

  logic              v8_r;
  tail_t             t8_r;
  logic signed [PROD_W-1:0] q1s_nxt, q2s_nxt, q1s_r, q2s_r;

  logic              out_valid_r;
  logic signed [COORD_W-1:0] out_a_r, out_b_r, out_c_r;
  logic              out_spec_r, out_sat_r;
  logic [COORD_W:0]  sat_a, sat_b, sat_c;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;
  assign pready   = 1'b1;
  assign prdata   = (paddr[ADDR_W-1] == REG_THRESHOLD) ? DATA_W'(thr_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (psel && penable && pwrite && (paddr[ADDR_W-1] == REG_THRESHOLD)) begin
      thr_r <= pwdata[THR_W-1:0];
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < SQ_STAGES; k++) sv_r[k] <= 1'b0;
      for (int k = 0; k < DIV_STAGES; k++) dv_r[k] <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      sv_r[0] <= v3_r;
      for (int k = 1; k < SQ_STAGES; k++) sv_r[k] <= sv_r[k-1];
      v4_r <= sv_r[SQL];
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      dv_r[0] <= v7_r;
      for (int k = 1; k < DIV_STAGES; k++) dv_r[k] <= dv_r[k-1];
      v8_r <= dv_r[DVL];
      out_valid_r <= v8_r;
    end
  end

  // Clamp, axis products, radicands.
  always_ff @(posedge clk) begin
    if (adv) begin
      g1_r.op <= in_op;
      g1_r.x  <= in_coord_a;
      g1_r.y  <= in_coord_b;
      g1_r.z  <= in_coord_c;
      g1_r.u  <= clamp_axis(in_axis_u);
      g1_r.v  <= clamp_axis(in_axis_v);
      g1_r.w  <= clamp_axis(in_axis_w);
      g1_r.uw <= '0;
      g1_r.vw <= '0;
      g1_r.uv <= '0;

      g2_r   <= g1_r;
      ww2_r  <= g1_r.w * g1_r.w;
      vv2_r  <= g1_r.v * g1_r.v;
      uwp2_r <= g1_r.u * g1_r.w;
      vwp2_r <= g1_r.v * g1_r.w;
      uvp2_r <= g1_r.u * g1_r.v;

      g3_r.op <= g2_r.op;
      g3_r.x  <= g2_r.x;
      g3_r.y  <= g2_r.y;
      g3_r.z  <= g2_r.z;
      g3_r.u  <= g2_r.u;
      g3_r.v  <= g2_r.v;
      g3_r.w  <= g2_r.w;
      g3_r.uw <= AXIS_W'(round_q46(uwp2_r));
      g3_r.vw <= AXIS_W'(round_q46(vwp2_r));
      g3_r.uv <= AXIS_W'(round_q46(uvp2_r));
      radw3_r <= (ww2_r >= ONE_SQ) ? '0 : RAD_W'(ONE_SQ - ww2_r);
      radv3_r <= (vv2_r >= ONE_SQ) ? '0 : RAD_W'(ONE_SQ - vv2_r);
    end
  end

  // Square-root pipelines for w and v, one root bit per stage.
  always_comb begin
    swx_in[0] = radw3_r;
    swr_in[0] = '0;
    svx_in[0] = radv3_r;
    svr_in[0] = '0;
    for (int k = 1; k < SQ_STAGES; k++) begin
      swx_in[k] = swx_r[k-1];
      swr_in[k] = swr_r[k-1];
      svx_in[k] = svx_r[k-1];
      svr_in[k] = svr_r[k-1];
    end
    for (int k = 0; k < SQ_STAGES; k++) begin
      {swx_nxt[k], swr_nxt[k]} =
        sqrt_step(swx_in[k], swr_in[k], RAD_W'(1) << (2 * (SQL - k)));
      {svx_nxt[k], svr_nxt[k]} =
        sqrt_step(svx_in[k], svr_in[k], RAD_W'(1) << (2 * (SQL - k)));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sg_r[0] <= g3_r;
      for (int k = 1; k < SQ_STAGES; k++) sg_r[k] <= sg_r[k-1];
      for (int k = 0; k < SQ_STAGES; k++) begin
        swx_r[k] <= swx_nxt[k];
        swr_r[k] <= swr_nxt[k];
        svx_r[k] <= svx_nxt[k];
        svr_r[k] <= svr_nxt[k];
      end
    end
  end

  // Matrix choice.
  always_ff @(posedge clk) begin
    if (adv) begin
      g4_r    <= sg_r[SQL];
      spec4_r <= !(ROOT_W'(swr_r[SQL]) > thr_r);
      s4_r    <= (ROOT_W'(swr_r[SQL]) > thr_r) ? ROOT_W'(swr_r[SQL]) : ROOT_W'(svr_r[SQL]);
    end
  end

  // Operand selection for the eight products.
  always_comb begin
    mode5_nxt = mode_t'({g4_r.op, spec4_r});
    for (int k = 0; k < 8; k++) begin
      ma[k] = '0;
      mb[k] = '0;
    end
    unique case (mode5_nxt)
      MODE_L2G: begin
        ma[0] = g4_r.uw; mb[0] = g4_r.x;
        ma[1] = g4_r.v;  mb[1] = g4_r.y;
        ma[2] = g4_r.vw; mb[2] = g4_r.x;
        ma[3] = g4_r.u;  mb[3] = g4_r.y;
        ma[4] = g4_r.u;  mb[4] = g4_r.z;
        ma[5] = g4_r.v;  mb[5] = g4_r.z;
        ma[6] = g4_r.w;  mb[6] = g4_r.z;
        ma[7] = $signed({1'b0, s4_r}); mb[7] = g4_r.x;
      end
      MODE_L2G_SPEC: begin
        ma[0] = g4_r.w;  mb[0] = g4_r.x;
        ma[1] = g4_r.uv; mb[1] = g4_r.y;
        ma[2] = g4_r.u;  mb[2] = g4_r.x;
        ma[3] = g4_r.vw; mb[3] = g4_r.y;
        ma[4] = g4_r.u;  mb[4] = g4_r.z;
        ma[5] = g4_r.v;  mb[5] = g4_r.z;
        ma[6] = g4_r.w;  mb[6] = g4_r.z;
        ma[7] = $signed({1'b0, s4_r}); mb[7] = g4_r.y;
      end
      MODE_G2L: begin
        ma[0] = g4_r.uw; mb[0] = g4_r.x;
        ma[1] = g4_r.vw; mb[1] = g4_r.y;
        ma[2] = g4_r.u;  mb[2] = g4_r.y;
        ma[3] = g4_r.v;  mb[3] = g4_r.x;
        ma[4] = $signed({1'b0, s4_r}); mb[4] = g4_r.z;
        ma[5] = g4_r.u;  mb[5] = g4_r.x;
        ma[6] = g4_r.v;  mb[6] = g4_r.y;
        ma[7] = g4_r.w;  mb[7] = g4_r.z;
      end
      MODE_G2L_SPEC: begin
        ma[0] = g4_r.w;  mb[0] = g4_r.x;
        ma[1] = g4_r.u;  mb[1] = g4_r.z;
        ma[2] = g4_r.uv; mb[2] = g4_r.x;
        ma[3] = g4_r.vw; mb[3] = g4_r.z;
        ma[4] = $signed({1'b0, s4_r}); mb[4] = g4_r.y;
        ma[5] = g4_r.u;  mb[5] = g4_r.x;
        ma[6] = g4_r.v;  mb[6] = g4_r.y;
        ma[7] = g4_r.w;  mb[7] = g4_r.z;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_r    <= s4_r;
      mode5_r <= mode5_nxt;
      for (int k = 0; k < 8; k++) p5_r[k] <= ma[k] * mb[k];
    end
  end

  // Numerator and undivided sums.
  always_comb begin
    n1_nxt = '0;
    n2_nxt = '0;
    da_nxt = '0;
    db_nxt = '0;
    dc_nxt = '0;
    unique case (mode5_r)
      MODE_L2G: begin
        n1_nxt = p5_r[0] - p5_r[1];
        n2_nxt = p5_r[2] + p5_r[3];
        da_nxt = p5_r[4];
        db_nxt = p5_r[5];
        dc_nxt = p5_r[6] - p5_r[7];
      end
      MODE_L2G_SPEC: begin
        n1_nxt = p5_r[0] - p5_r[1];
        n2_nxt = -p5_r[2] - p5_r[3];
        da_nxt = p5_r[4];
        db_nxt = p5_r[5] + p5_r[7];
        dc_nxt = p5_r[6];
      end
      MODE_G2L: begin
        n1_nxt = p5_r[0] + p5_r[1];
        n2_nxt = p5_r[2] - p5_r[3];
        da_nxt = -p5_r[4];
        dc_nxt = p5_r[5] + p5_r[6] + p5_r[7];
      end
      MODE_G2L_SPEC: begin
        n1_nxt = p5_r[0] - p5_r[1];
        n2_nxt = -p5_r[2] - p5_r[3];
        db_nxt = p5_r[4];
        dc_nxt = p5_r[5] + p5_r[6] + p5_r[7];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_r    <= s5_r;
      mode6_r <= mode5_r;
      n1_r    <= n1_nxt;
      n2_r    <= n2_nxt;
      da6_r   <= da_nxt;
      db6_r   <= db_nxt;
      dc6_r   <= dc_nxt;
    end
  end

  // Rounded dividend magnitudes and rounded undivided terms.
  assign half6 = $signed(PROD_W'(s6_r >> 1));

  always_ff @(posedge clk) begin
    if (adv) begin
      d7_r <= s6_r;
      m1_r <= DIVD_W'(n1_r[PROD_W-1] ? half6 - n1_r : half6 + n1_r);
      m2_r <= DIVD_W'(n2_r[PROD_W-1] ? half6 - n2_r : half6 + n2_r);
      t7_r.da      <= round_q46(da6_r);
      t7_r.db      <= round_q46(db6_r);
      t7_r.dc      <= round_q46(dc6_r);
      t7_r.n1_neg  <= n1_r[PROD_W-1];
      t7_r.n2_neg  <= n2_r[PROD_W-1];
      t7_r.n1_nz   <= (n1_r != '0);
      t7_r.n2_nz   <= (n2_r != '0);
      t7_r.dz      <= (s6_r == '0);
      t7_r.q2_to_c <= (mode6_r == MODE_L2G_SPEC);
      t7_r.special <= (mode6_r == MODE_L2G_SPEC) || (mode6_r == MODE_G2L_SPEC);
    end
  end

  // Restoring divider pipelines, one quotient bit per stage.
  always_comb begin
    dn1_in[0] = m1_r;
    dr1_in[0] = '0;
    dn2_in[0] = m2_r;
    dr2_in[0] = '0;
    dd_in[0]  = d7_r;
    for (int k = 1; k < DIV_STAGES; k++) begin
      dn1_in[k] = dn1_r[k-1];
      dr1_in[k] = dr1_r[k-1];
      dn2_in[k] = dn2_r[k-1];
      dr2_in[k] = dr2_r[k-1];
      dd_in[k]  = dd_r[k-1];
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      {dn1_nxt[k], dr1_nxt[k]} = div_step(dn1_in[k], dr1_in[k], dd_in[k]);
      {dn2_nxt[k], dr2_nxt[k]} = div_step(dn2_in[k], dr2_in[k], dd_in[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dt_r[0] <= t7_r;
      for (int k = 1; k < DIV_STAGES; k++) dt_r[k] <= dt_r[k-1];
      for (int k = 0; k < DIV_STAGES; k++) begin
        dn1_r[k] <= dn1_nxt[k];
        dr1_r[k] <= dr1_nxt[k];
        dn2_r[k] <= dn2_nxt[k];
        dr2_r[k] <= dr2_nxt[k];
        dd_r[k]  <= dd_in[k];
      end
    end
  end

  // Signed quotients, with the fixed large value for a zero divisor.
  always_comb begin
    if (dt_r[DVL].dz) begin
      q1s_nxt = !dt_r[DVL].n1_nz ? '0 : (dt_r[DVL].n1_neg ? -BIG_QUOT : BIG_QUOT);
      q2s_nxt = !dt_r[DVL].n2_nz ? '0 : (dt_r[DVL].n2_neg ? -BIG_QUOT : BIG_QUOT);
    end else begin
      q1s_nxt = dt_r[DVL].n1_neg ? -$signed({1'b0, dn1_r[DVL]}) : $signed({1'b0, dn1_r[DVL]});
      q2s_nxt = dt_r[DVL].n2_neg ? -$signed({1'b0, dn2_r[DVL]}) : $signed({1'b0, dn2_r[DVL]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t8_r  <= dt_r[DVL];
      q1s_r <= q1s_nxt;
      q2s_r <= q2s_nxt;
    end
  end

  // Final sums and saturation into the output register.
  always_comb begin
    sat_a = sat_coord(SUM_W'(t8_r.da) + SUM_W'(q1s_r));
    sat_b = sat_coord(SUM_W'(t8_r.db) + (t8_r.q2_to_c ? '0 : SUM_W'(q2s_r)));
    sat_c = sat_coord(SUM_W'(t8_r.dc) + (t8_r.q2_to_c ? SUM_W'(q2s_r) : '0));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_a_r    <= sat_a[COORD_W-1:0];
      out_b_r    <= sat_b[COORD_W-1:0];
      out_c_r    <= sat_c[COORD_W-1:0];
      out_spec_r <= t8_r.special;
      out_sat_r  <= t8_r.dz || sat_a[COORD_W] || sat_b[COORD_W] || sat_c[COORD_W];
    end
  end

  assign out_valid             = out_valid_r;
  assign out_a                 = out_a_r;
  assign out_b                 = out_b_r;
  assign out_c                 = out_c_r;
  assign out_used_special_case = out_spec_r;
  assign out_saturated         = out_sat_r;

  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r[SQL] |-> (swr_r[SQL] <= ROOT_MAX) && (svr_r[SQL] <= ROOT_MAX))
    else $error("square root result exceeds one");

  a_normal_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && (mode5_r == MODE_L2G || mode5_r == MODE_G2L) |-> s5_r != '0)
    else $error("normal matrix chosen with a zero polar sine");

  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[DVL] && (dd_r[DVL] != '0) |-> (dr1_r[DVL] < dd_r[DVL]) && (dr2_r[DVL] < dd_r[DVL]))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the polar-axis frame rotation block: directed and random
// rotations are predicted in place and compared with every result transfer.
// Depends on pafr_pkg and polar_axis_frame_rotation_top.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pafr_pkg::*;

  localparam int LATENCY    = 103;
  localparam int IDLE_LIMIT = 20000;
  localparam real Q30       = 1073741824.0;

  typedef struct packed {
    logic                      op;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [AXIS_W-1:0]  u;
    logic signed [AXIS_W-1:0]  v;
    logic signed [AXIS_W-1:0]  w;
  } rot_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] a;
    logic signed [COORD_W-1:0] b;
    logic signed [COORD_W-1:0] c;
    logic                      spec;
    logic                      sat;
  } rot_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_op = 1'b0;
  logic signed [COORD_W-1:0] in_coord_a = '0, in_coord_b = '0, in_coord_c = '0;
  logic signed [AXIS_W-1:0] in_axis_u = '0, in_axis_v = '0, in_axis_w = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [COORD_W-1:0] out_a, out_b, out_c;
  logic out_used_special_case, out_saturated;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  rot_result_t rotation_expected[$];
  logic [THR_W-1:0] sine_threshold = THR_RESET;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_len = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  polar_axis_frame_rotation_top u_top (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned magnitude(longint a);
    return a < 0 ? longint'(-a) : a;
  endfunction

  function automatic longint round_q30(longint a);
    longint unsigned m;
    m = (magnitude(a) + (64'd1 << (AXIS_FRAC - 1))) >> AXIS_FRAC;
    return a < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint divide_round(longint num, longint den, inout bit flag);
    longint unsigned q;
    if (den <= 0) begin
      flag = 1'b1;
      if (num > 0) return 64'sd1 <<< 62;
      if (num < 0) return -(64'sd1 <<< 62);
      return 0;
    end
    q = (magnitude(num) + longint'(den) / 2) / longint'(den);
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint floor_root(longint unsigned x);
    longint unsigned r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint sine_of(longint a);
    longint sq, one2;
    sq = a * a;
    one2 = 64'sd1 <<< (2 * AXIS_FRAC);
    if (sq >= one2) return 0;
    return floor_root(longint'(one2 - sq));
  endfunction

  function automatic longint clamp_unit(logic signed [AXIS_W-1:0] a);
    longint t, one;
    t = a;
    one = 64'sd1 <<< AXIS_FRAC;
    if (t > one) return one;
    if (t < -one) return -one;
    return t;
  endfunction

  function automatic logic signed [COORD_W-1:0] clip(longint a, inout bit flag);
    longint hi, lo;
    hi = (64'sd1 <<< (COORD_W - 1)) - 1;
    lo = -hi - 1;
    if (a > hi) begin
      flag = 1'b1;
      return COORD_W'(hi);
    end
    if (a < lo) begin
      flag = 1'b1;
      return COORD_W'(lo);
    end
    return COORD_W'(a);
  endfunction

  function automatic rot_result_t predict_rotation(rot_item_t it);
    rot_result_t r;
    bit flag, spec;
    longint x, y, z, u, v, w, s, uw, vw, uv, ra, rb, rc;
    flag = 1'b0;
    x = it.x;
    y = it.y;
    z = it.z;
    u = clamp_unit(it.u);
    v = clamp_unit(it.v);
    w = clamp_unit(it.w);
    s = sine_of(w);
    uw = round_q30(u * w);
    vw = round_q30(v * w);
    uv = round_q30(u * v);
    spec = !(s > longint'(sine_threshold));
    if (spec) s = sine_of(v);
    if (it.op == 1'b0) begin
      if (!spec) begin
        ra = round_q30(u * z) + divide_round(uw * x - v * y, s, flag);
        rb = round_q30(v * z) + divide_round(vw * x + u * y, s, flag);
        rc = round_q30(w * z - s * x);
      end else begin
        ra = round_q30(u * z) + divide_round(w * x - uv * y, s, flag);
        rb = round_q30(v * z + s * y);
        rc = round_q30(w * z) - divide_round(u * x + vw * y, s, flag);
      end
    end else begin
      if (!spec) begin
        ra = divide_round(uw * x + vw * y, s, flag) - round_q30(s * z);
        rb = divide_round(u * y - v * x, s, flag);
      end else begin
        ra = divide_round(w * x - u * z, s, flag);
        rb = round_q30(s * y) - divide_round(uv * x + vw * z, s, flag);
      end
      rc = round_q30(u * x + v * y + w * z);
    end
    r.a = clip(ra, flag);
    r.b = clip(rb, flag);
    r.c = clip(rc, flag);
    r.spec = spec;
    r.sat = flag;
    return r;
  endfunction

  task automatic send_rotation(rot_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_op = it.op;
    in_coord_a = it.x;
    in_coord_b = it.y;
    in_coord_c = it.z;
    in_axis_u = it.u;
    in_axis_v = it.v;
    in_axis_w = it.w;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    rotation_expected.push_back(predict_rotation(it));
    @(negedge clk);
  endtask

  task automatic drain_pipeline();
    in_valid = 1'b0;
    wait (rotation_expected.size() == 0);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] value);
    drain_pipeline();
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = ADDR_W'(4 * REG_THRESHOLD);
    pwdata = DATA_W'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sine_threshold = value;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic logic signed [AXIS_W-1:0] to_q30(real r);
    return AXIS_W'($rtoi(r * Q30));
  endfunction

  function automatic logic signed [COORD_W-1:0] random_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return COORD_W'($signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
      2: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return COORD_W'($signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000);
    endcase
  endfunction

  function automatic rot_item_t random_rotation();
    rot_item_t it;
    real w, s, ang, uu;
    it.op = 1'($urandom_range(1));
    it.x = random_coord();
    it.y = random_coord();
    it.z = random_coord();
    case ($urandom_range(9))
      0: begin
        it.u = $urandom;
        it.v = $urandom;
        it.w = $urandom;
      end
      1: begin
        it.u = $urandom_range(1) ? AXIS_ONE : -AXIS_ONE;
        it.v = $urandom_range(1) ? AXIS_ONE : 32'sd0;
        it.w = $urandom_range(1) ? AXIS_ONE : -AXIS_ONE;
      end
      2, 3: begin
        it.w = $urandom_range(1) ? AXIS_ONE - $urandom_range(40000) :
                                   -AXIS_ONE + $urandom_range(40000);
        it.u = $signed($urandom_range(80000)) - 40000;
        it.v = $signed($urandom_range(80000)) - 40000;
      end
      default: begin
        w = 2.0 * ($urandom / 4294967296.0) - 1.0;
        s = $sqrt(1.0 - w * w);
        ang = 6.283185307 * ($urandom / 4294967296.0);
        uu = s * $cos(ang);
        it.u = to_q30(uu);
        it.v = to_q30(s * $sin(ang));
        it.w = to_q30(w);
      end
    endcase
    return it;
  endfunction

  task automatic test_directed();
    rot_item_t it;
    logic signed [AXIS_W-1:0] ax [6][3];
    ax = '{'{0, 0, AXIS_ONE}, '{0, 0, -AXIS_ONE}, '{AXIS_ONE, 0, 0},
           '{0, AXIS_ONE, 0}, '{0, AXIS_ONE, AXIS_ONE},
           '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff}};
    for (int i = 0; i < 6; i++) begin
      for (int op = 0; op < 2; op++) begin
        it.op = 1'(op);
        it.u = ax[i][0];
        it.v = ax[i][1];
        it.w = ax[i][2];
        it.x = (i == 4 && op == 1) ? 32'sd0 : 32'sh7fff_ffff;
        it.y = (i == 4 && op == 1) ? 32'sd0 : 32'sh8000_0000;
        it.z = (i == 4 && op == 1) ? 32'sd0 : 32'sh0001_0000;
        send_rotation(it);
      end
    end
    it = '{1'b0, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 0, 0, AXIS_ONE};
    send_rotation(it);
    it = '{1'b1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
           32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
    send_rotation(it);
  endtask

  task automatic test_random(int count, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_rotation(random_rotation());
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_len = 400;
    repeat (250) send_rotation(random_rotation());
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(500, 24, 54);
    write_threshold('0);
    test_directed();
    test_random(300, 54, 24);
    write_threshold(THR_W'(31'h7fff_ffff));
    test_random(200, 0, 0);
    write_threshold(THR_W'(1 << 28));
    test_random(400, 24, 54);
    write_threshold(THR_W'(1 << 30));
    test_random(100, 0, 0);
    write_threshold(THR_W'(20000));
    test_backpressure();
    drain_pipeline();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len <= hold_len - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    rot_result_t exp_r, got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_a, out_b, out_c, out_used_special_case, out_saturated};
      if (rotation_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transfer: %p", got);
      end else begin
        exp_r = rotation_expected.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("Result mismatch: expected %p, got %p", exp_r, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
